[rtl/core/sidac_pkg.sv]
package sidac_pkg;

	localparam int unsigned MAG_W = 32;
	localparam int unsigned MULT_W = 34;
	localparam int unsigned IDX_W = 4;
	localparam int unsigned NUM_DIGITS = 10;
	localparam logic [IDX_W-1:0] TOP_IDX = 4'd9;

	localparam logic [7:0] ASCII_ZERO = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;
	localparam logic [7:0] ASCII_NINE = 8'd57;

	// One queued conversion: sign, magnitude and the position of its leading digit.
	typedef struct packed {
		logic neg;
		logic [MAG_W-1:0] mag;
		logic [IDX_W-1:0] top;
	} cmd_t;

	typedef logic [NUM_DIGITS-1:0][NUM_DIGITS-1:0][MULT_W-1:0] mult_tab_t;

	// Entry [k][d] holds d times ten to the power k.
	function automatic mult_tab_t build_mult();
		mult_tab_t tab;
		logic [63:0] p;
		logic [63:0] prod;
		p = 64'd1;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				prod = p * 64'(d);
				tab[k][d] = prod[MULT_W-1:0];
			end
			p = p * 64'd10;
		end
		return tab;
	endfunction

	localparam mult_tab_t DEC_MULT = build_mult();

endpackage

[rtl/core/sidac_front.sv]
module sidac_front
	import sidac_pkg::*;
(
	input  logic [31:0] value,
	output cmd_t        cmd
);

	logic            neg;
	logic [MAG_W-1:0] mag;
	logic [IDX_W-1:0] top;

	// The most negative value negates to itself, which read unsigned is its magnitude.
	assign neg = value[31];
	assign mag = neg ? (32'd0 - value) : value;

	always_comb begin
		top = '0;
		for (int k = 1; k < NUM_DIGITS; k++) begin
			if ({2'b00, mag} >= DEC_MULT[k][1]) begin
				top = IDX_W'(k);
			end
		end
	end

	assign cmd.neg = neg;
	assign cmd.mag = mag;
	assign cmd.top = top;

endmodule

[rtl/core/sidac_fifo.sv]
module sidac_fifo
	import sidac_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign valid = (cnt_q != '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && valid;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/sidac_back.sv]
module sidac_back
	import sidac_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cmd_t       q_data,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] char_code,
	output logic       last
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIGITS = 1'b1;

	logic             state_q;
	logic [MAG_W-1:0] rem_q;
	logic [IDX_W-1:0] k_q;
	logic             out_valid_q;
	logic [7:0]       char_q;
	logic             last_q;

	logic             out_free;
	logic             step;
	logic             emit_sign;
	logic [MAG_W-1:0] src_rem;
	logic [IDX_W-1:0] src_k;
	logic [IDX_W-1:0] digit;
	logic [MAG_W-1:0] rem_next;
	logic [MULT_W-1:0] sub_val;

	assign out_free = !out_valid_q || pop;
	assign step = out_free && ((state_q == ST_DIGITS) || q_valid);
	assign emit_sign = (state_q == ST_IDLE) && q_data.neg;
	assign q_pop = step && (state_q == ST_IDLE);

	// In idle the head of the queue feeds the digit unit directly, so its first
	// character is loaded into the output register in the cycle it is taken.
	assign src_rem = (state_q == ST_DIGITS) ? rem_q : q_data.mag;
	assign src_k = (state_q == ST_DIGITS) ? k_q : q_data.top;

	always_comb begin
		digit = '0;
		for (int m = 1; m < NUM_DIGITS; m++) begin
			if ({2'b00, src_rem} >= DEC_MULT[src_k][m]) begin
				digit = IDX_W'(m);
			end
		end
	end

	assign sub_val = DEC_MULT[src_k][digit];
	assign rem_next = src_rem - sub_val[MAG_W-1:0];

	always_ff @(posedge clk) begin
		if (step) begin
			if (emit_sign) begin
				char_q <= ASCII_MINUS;
				last_q <= 1'b0;
				rem_q <= q_data.mag;
				k_q <= q_data.top;
			end else begin
				char_q <= ASCII_ZERO + {4'd0, digit};
				last_q <= (src_k == '0);
				rem_q <= rem_next;
				k_q <= src_k - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				out_valid_q <= 1'b1;
				state_q <= (emit_sign || (src_k != '0)) ? ST_DIGITS : ST_IDLE;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty = !out_valid_q;
	assign char_code = char_q;
	assign last = last_q;

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (char_q == ASCII_MINUS ||
			(char_q >= ASCII_ZERO && char_q <= ASCII_NINE)))
		else $error("illegal character in output register");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && char_q == ASCII_MINUS) |-> !last_q)
		else $error("minus sign marked as the final character");

	a_digit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGITS) |-> (k_q <= TOP_IDX))
		else $error("digit position out of range");

	a_run_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !emit_sign && src_k == '0) |=> (state_q == ST_IDLE && last_q))
		else $error("final digit did not close the run");

endmodule

[rtl/core/signed_int_to_decimal_ascii.sv]
// Converts each signed 32-bit word pushed at the input into its decimal ASCII text,
// most significant character first, one character per output word, with a leading
// '-' for negative values, no leading zeros, and last set on the final character.
// The front end classifies a word in the cycle it is accepted (sign, magnitude and
// digit count) and places it in a queue of QUEUE_DEPTH entries; the digit unit then
// produces one character per cycle unless the output stalls; a value has 1 to 11
// characters, the next following once the final one is registered. The digit unit
// is the rate-setting part; output stalls hold it while the queue fills with input.
module signed_int_to_decimal_ascii
	import sidac_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] value,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  char_code,
	output logic        last
);

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic head_valid;
	logic head_pop;

	sidac_front u_front (
		.value (value),
		.cmd   (front_cmd)
	);

	sidac_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_cmd),
		.full    (full),
		.rd_en   (head_pop),
		.rd_data (head_cmd),
		.valid   (head_valid)
	);

	sidac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (head_valid),
		.q_data    (head_cmd),
		.q_pop     (head_pop),
		.empty     (empty),
		.pop       (pop),
		.char_code (char_code),
		.last      (last)
	);

endmodule

[sim/decimal_text_checker.sv]
`timescale 1ns / 100ps

module decimal_text_checker
	import sidac_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [31:0] value,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  char_code,
	input  logic        last,
	input  logic        drain,
	output int          failures,
	output int          outstanding
);

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} char_word_t;

	char_word_t expected_chars[$];
	char_word_t want;
	logic       drain_seen;

	initial begin
		failures = 0;
		outstanding = 0;
		drain_seen = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("checker: %s", msg);
		failures++;
	endtask

	// Appends the decimal text of one input word to the expected characters.
	function automatic void spell_decimal(input logic [31:0] word);
		logic        neg;
		logic [31:0] mag;
		logic [31:0] rem;
		logic [3:0]  digit_buf[NUM_DIGITS];
		int          nd;
		char_word_t  w;
		neg = word[31];
		mag = neg ? (~word + 32'd1) : word;
		nd = 0;
		do begin
			rem = mag % 32'd10;
			digit_buf[nd] = rem[3:0];
			mag = mag / 32'd10;
			nd++;
		end while (mag != 32'd0 && nd < NUM_DIGITS);
		if (neg) begin
			w.code = ASCII_MINUS;
			w.last = 1'b0;
			expected_chars.push_back(w);
		end
		for (int k = nd - 1; k >= 0; k--) begin
			w.code = ASCII_ZERO + {4'd0, digit_buf[k]};
			w.last = (k == 0);
			expected_chars.push_back(w);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_chars.delete();
			outstanding <= 0;
		end else begin
			if (push && !full) begin
				spell_decimal(value);
			end
			if (pop && !empty) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected word char_code=%0d last=%0b",
						char_code, last));
				end else begin
					want = expected_chars.pop_front();
					if (char_code !== want.code) begin
						report_mismatch($sformatf("char_code got %0d, expected %0d",
							char_code, want.code));
					end
					if (last !== want.last) begin
						report_mismatch($sformatf("last got %0b, expected %0b on char %0d",
							last, want.last, want.code));
					end
				end
			end
			if (drain && !drain_seen) begin
				drain_seen = 1'b1;
				if (expected_chars.size() != 0) begin
					report_mismatch($sformatf("%0d expected words never arrived",
						expected_chars.size()));
				end
			end
			outstanding <= expected_chars.size();
		end
	end

endmodule

[sim/signed_int_to_decimal_ascii_test.sv]
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_test;

	localparam int RANDOM_WORDS = 160;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_PERCENT = 36;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [31:0] value = 32'd0;
	logic        pop = 1'b0;
	logic        drain = 1'b0;
	logic        full;
	logic        empty;
	logic [7:0]  char_code;
	logic        last;
	int          failures;
	int          outstanding;

	int          cycles = 0;
	logic        quiet = 1'b0;
	logic        hold_rx = 1'b0;

	logic [31:0] directed_words[] = '{
		32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'h7FFF_FFFF,
		32'h8000_0000, 32'h8000_0001, 32'd1000000000, -32'sd999999999, 32'd99,
		32'd100, 32'h5555_5555, 32'hAAAA_AAAA, 32'd123456789, -32'sd7, 32'd4000
	};

	always #5 clk = ~clk;

	signed_int_to_decimal_ascii i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.value     (value),
		.empty     (empty),
		.pop       (pop),
		.char_code (char_code),
		.last      (last)
	);

	decimal_text_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.value       (value),
		.empty       (empty),
		.pop         (pop),
		.char_code   (char_code),
		.last        (last),
		.drain       (drain),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [31:0] pick_value();
		logic [31:0] p;
		case ($urandom_range(3))
			0: pick_value = $urandom;
			1: pick_value = 32'($urandom_range(200)) - 32'd100;
			2: begin
				p = 32'd1;
				repeat ($urandom_range(9)) p = p * 32'd10;
				p = p + 32'($urandom_range(2)) - 32'd1;
				pick_value = $urandom_range(1) ? (~p + 32'd1) : p;
			end
			default: begin
				p = $urandom >> $urandom_range(31);
				pick_value = $urandom_range(1) ? (~p + 32'd1) : p;
			end
		endcase
	endfunction

	// Offers one word, idling first unless in the quiet stretch, and returns once
	// the block has taken it.
	task automatic send_word(input logic [31:0] v);
		while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		value <= v;
		do @(posedge clk); while (full);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Receiver: random pops, and one long hold-off when the sender asks for it.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end else begin
				pop <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_words[i]) send_word(directed_words[i]);
		wait_drained();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 40) begin
				wait_drained();
			end
			if (n == 70) begin
				hold_rx = 1'b1;
			end
			quiet = (n >= 100 && n < 140);
			send_word(pick_value());
		end
		quiet = 1'b0;
		wait_drained();

		repeat (30) @(posedge clk);
		drain <= 1'b1;
		repeat (3) @(posedge clk);
		if (failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/sidac_pkg.sv
rtl/core/sidac_front.sv
rtl/core/sidac_fifo.sv
rtl/core/sidac_back.sv
rtl/core/signed_int_to_decimal_ascii.sv
sim/decimal_text_checker.sv
sim/signed_int_to_decimal_ascii_test.sv
